FILE: hdl/tape_level_rle_byte_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tape level RLE byte encoder
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TAPE_LEVEL_RLE_BYTE_ENCODER_UNIT_ASSERT_SVH
`define TAPE_LEVEL_RLE_BYTE_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define TLRE_ASSERT_NOW(label, ck, rstn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tlre same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante
`define TLRE_ASSERT_NEXT(label, ck, rstn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tlre next-cycle check failed");

`endif

FILE: hdl/tlre_pkg.sv
// ----------------------------------------------------------------------------
// tlre_pkg
// Shared types and constants of the tape level RLE byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tlre_pkg;

    // Width of the sample and run counters (16 to 32)
    localparam int COUNT_BITS = 32;

    // Depth of the command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    // Encoded byte values
    localparam logic [7:0]  BYTE_HIGH     = 8'hE0;
    localparam logic [7:0]  BYTE_LOW      = 8'h20;
    localparam logic [31:0] SHORT_RUN_MAX = 32'd255;

    // Input item kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] REG_RLE_MODE   = 8'd0;
    localparam logic [7:0] REG_INIT_LEVEL = 8'd1;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,   // one data byte
        CMD_COUNT = 2'd1,   // count-only report
        CMD_RUN   = 2'd2    // run length, one or five bytes
    } tlre_cmd_kind_t;

    typedef struct packed {
        tlre_cmd_kind_t kind;
        logic [7:0]     byte_val;
        logic [31:0]    run_len;
        logic [31:0]    count;
    } tlre_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tlre_fifo_stat_t;

    // Saturating increment of a counter
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tlre_front.sv
// ----------------------------------------------------------------------------
// tlre_front
// Accepts items and config writes, tracks recording state, issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tlre_front
    import tlre_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        kind,
    input  wire logic        level,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_index,
    input  wire logic        cfg_bit,
    output logic             push,
    output tlre_cmd_t        cmd
);

    logic                  rle_mode_reg,   rle_mode_next;
    logic                  init_level_reg, init_level_next;
    logic [COUNT_BITS-1:0] rec_reg,        rec_next;
    logic                  run_level_reg,  run_level_next;
    logic [COUNT_BITS-1:0] run_len_reg,    run_len_next;
    logic [COUNT_BITS-1:0] rec_inc;

    assign rec_inc = sat_inc(rec_reg);

    // Classify the item, update recording state, build the command
    always_comb
    begin
        rle_mode_next   = rle_mode_reg;
        init_level_next = init_level_reg;
        rec_next        = rec_reg;
        run_level_next  = run_level_reg;
        run_len_next    = run_len_reg;
        push            = 1'b0;
        cmd.kind        = CMD_COUNT;
        cmd.byte_val    = 8'd0;
        cmd.run_len     = 32'(run_len_reg);
        cmd.count       = 32'(rec_reg);

        if (accept)
        begin
            if (kind == KIND_FINISH)
            begin
                push           = 1'b1;
                cmd.kind       = rle_mode_reg ? CMD_RUN : CMD_COUNT;
                rec_next       = '0;
                run_level_next = init_level_reg;
                run_len_next   = COUNT_BITS'(1);
            end
            else if (!((rec_reg == '0) && (level == init_level_reg)))
            begin
                rec_next  = rec_inc;
                cmd.count = 32'(rec_inc);
                if (!rle_mode_reg)
                begin
                    push         = 1'b1;
                    cmd.kind     = CMD_BYTE;
                    cmd.byte_val = level ? BYTE_HIGH : BYTE_LOW;
                end
                else if (level == run_level_reg)
                begin
                    run_len_next = sat_inc(run_len_reg);
                end
                else
                begin
                    push           = 1'b1;
                    cmd.kind       = CMD_RUN;
                    run_level_next = level;
                    run_len_next   = COUNT_BITS'(1);
                end
            end
        end

        // Register writes (the user must write them only while idle; the block does not enforce this)
        if (cfg_we)
        begin
            if (cfg_index == REG_RLE_MODE)
            begin
                rle_mode_next = cfg_bit;
            end
            else if (cfg_index == REG_INIT_LEVEL)
            begin
                init_level_next = cfg_bit;
                if (rec_reg == '0)
                begin
                    run_level_next = cfg_bit;
                end
            end
        end
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg   <= 1'b1;
            init_level_reg <= 1'b0;
            rec_reg        <= '0;
            run_level_reg  <= 1'b0;
            run_len_reg    <= COUNT_BITS'(1);
        end
        else
        begin
            rle_mode_reg   <= rle_mode_next;
            init_level_reg <= init_level_next;
            rec_reg        <= rec_next;
            run_level_reg  <= run_level_next;
            run_len_reg    <= run_len_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tlre_fifo.sv
// ----------------------------------------------------------------------------
// tlre_fifo
// Short command queue that decouples the front from the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module tlre_fifo
    import tlre_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  tlre_cmd_t       wdata,
    input  wire logic       pop,
    output tlre_cmd_t       rdata,
    output tlre_fifo_stat_t stat
);

    tlre_cmd_t           mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg,    cnt_next;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (cnt_reg == CNT_BITS'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tlre_back.sv
// ----------------------------------------------------------------------------
// tlre_back
// Byte serializer: turns queued commands into output transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module tlre_back
    import tlre_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  tlre_cmd_t        head,
    input  wire logic        head_valid,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             has_data,
    output logic [31:0]      sample_count,
    output logic             last
);

    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg;
    logic        has_reg;
    logic [31:0] count_reg;
    logic        last_reg;
    logic [2:0]  idx_reg,   idx_next;
    logic        load;
    logic [7:0]  cur_byte;
    logic        cur_has;
    logic        cur_last;

    assign load         = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign has_data     = has_reg;
    assign sample_count = count_reg;
    assign last         = last_reg;

    // Decode the byte at the current position of the head command
    always_comb
    begin
        cur_byte = 8'd0;
        cur_has  = 1'b1;
        cur_last = 1'b1;
        unique case (head.kind)
            CMD_BYTE:
            begin
                cur_byte = head.byte_val;
            end
            CMD_COUNT:
            begin
                cur_has = 1'b0;
            end
            CMD_RUN:
            begin
                if (head.run_len <= SHORT_RUN_MAX)
                begin
                    cur_byte = head.run_len[7:0];
                end
                else
                begin
                    cur_last = (idx_reg == 3'd4);
                    case (idx_reg)
                        3'd1:    cur_byte = head.run_len[7:0];
                        3'd2:    cur_byte = head.run_len[15:8];
                        3'd3:    cur_byte = head.run_len[23:16];
                        3'd4:    cur_byte = head.run_len[31:24];
                        default: cur_byte = 8'd0;
                    endcase
                end
            end
            default:
            begin
                cur_has = 1'b0;
            end
        endcase
    end

    // Advance through the command, drop it after its last byte
    always_comb
    begin
        pop        = 1'b0;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                pop      = cur_last;
                idx_next = cur_last ? 3'd0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            byte_reg  <= cur_byte;
            has_reg   <= cur_has;
            count_reg <= head.count;
            last_reg  <= cur_last;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tape_level_rle_byte_encoder_unit.sv
// Tape level RLE byte encoder. Takes one tape level per sample tick on the
// slave stream (tuser = kind: 0 tick, 1 finish; tdata[0] = level) and emits
// encoded bytes on the master stream: a raw byte per recorded sample, or run
// lengths as one byte (up to 255) or a zero byte plus four little-endian count
// bytes; a finish item flushes the last run (or, in raw mode, gives one
// count-only report). An input item is taken every cycle while the four-entry
// command queue has room; the serializer sends one byte per cycle while the
// output is ready (a long run is five bytes, any other result one). Commands go
// through the queue and the output register. Registers are written through the
// cfg channel, which is always ready; write them only while the block is idle.
`default_nettype none

`include "tape_level_rle_byte_encoder_unit_assert.svh"

// ----------------------------------------------------------------------------
// tape_level_rle_byte_encoder_unit
// Top level: front classifier, command queue and byte serializer.
// ----------------------------------------------------------------------------
module tape_level_rle_byte_encoder_unit
    import tlre_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] level, [7:1] zero
    input  wire logic        s_axis_tuser,   // [0] kind
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] out_byte, [39:8] sample_count
    output logic             m_axis_tuser,   // [0] has_data
    output logic             m_axis_tlast,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    tlre_cmd_t       front_cmd;
    tlre_cmd_t       head_cmd;
    tlre_fifo_stat_t fifo_stat;
    logic            front_push;
    logic            back_pop;
    logic            in_accept;

    assign s_axis_tready = !fifo_stat.full;
    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Classify input transactions
    tlre_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .kind      (s_axis_tuser),
        .level     (s_axis_tdata[0]),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_bit   (cfg_data[0]),
        .push      (front_push),
        .cmd       (front_cmd)
    );

    // Queue commands
    tlre_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_cmd),
        .pop   (back_pop),
        .rdata (head_cmd),
        .stat  (fifo_stat)
    );

    // Serialize bytes
    tlre_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_cmd),
        .head_valid   (!fifo_stat.empty),
        .pop          (back_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (m_axis_tdata[7:0]),
        .has_data     (m_axis_tuser),
        .sample_count (m_axis_tdata[39:8]),
        .last         (m_axis_tlast)
    );

    // Checks
    `TLRE_ASSERT_NOW(a_no_overflow, clk, rst_n, front_push, !fifo_stat.full)
    `TLRE_ASSERT_NOW(a_count_only_last, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
    `TLRE_ASSERT_NOW(a_count_only_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
                     m_axis_tdata[7:0] == 8'd0)

endmodule

`default_nettype wire

FILE: sim/tape_level_rle_byte_encoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_level_rle_byte_encoder_unit_test
// Self-checking bench for the tape level RLE byte encoder. Sends tick and
// finish transactions on the input stream and predicts each output byte
// from its own copy of the encoder state: leading silence, raw bytes, short
// and long run lengths, flushes and count-only reports. Both streams idle in
// random bursts; every output transaction is compared against the oldest
// predicted byte.
// ----------------------------------------------------------------------------
module tape_level_rle_byte_encoder_unit_test;
    import tlre_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 10;

    typedef struct packed {
        logic [7:0]  code;
        logic        has_data;
        logic [31:0] count;
        logic        tail;
    } enc_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [0] level, [7:1] zero
    logic        s_axis_tuser = 1'b0;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [7:0] out_byte, [39:8] sample_count
    logic        m_axis_tuser;          // [0] has_data
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [7:0]  cfg_data = 8'd0;

    // Encoder copy: registers and recording state
    logic        rle_on;
    logic        silence_level;
    logic [31:0] recorded;
    logic        cur_level;
    logic [31:0] cur_run;

    enc_byte_t   expected_bytes[$];
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;

    tape_level_rle_byte_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [31:0] count_up(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void push_byte(input logic [7:0] code, input logic has,
                                      input logic tail);
        enc_byte_t b;
        b.code     = code;
        b.has_data = has;
        b.count    = recorded;
        b.tail     = tail;
        expected_bytes.push_back(b);
    endfunction

    // Queue the bytes of the current run: short form or zero plus four count bytes
    function automatic void push_run();
        if (cur_run <= SHORT_RUN_MAX)
        begin
            push_byte(cur_run[7:0], 1'b1, 1'b1);
        end
        else
        begin
            push_byte(8'd0, 1'b1, 1'b0);
            for (int i = 0; i < 4; i++)
                push_byte(cur_run[8*i +: 8], 1'b1, i == 3);
        end
    endfunction

    function automatic void restart_recording();
        recorded  = 32'd0;
        cur_level = silence_level;
        cur_run   = 32'd1;
    endfunction

    function automatic void encode_item(input logic kind, input logic level);
        if (kind == KIND_FINISH)
        begin
            if (rle_on)
                push_run();
            else
                push_byte(8'd0, 1'b0, 1'b1);
            restart_recording();
        end
        else if (!(recorded == 32'd0 && level == silence_level))
        begin
            recorded = count_up(recorded);
            if (!rle_on)
                push_byte(level ? BYTE_HIGH : BYTE_LOW, 1'b1, 1'b1);
            else if (level == cur_level)
                cur_run = count_up(cur_run);
            else
            begin
                cur_level = level;
                push_run();
                cur_run = 32'd1;
            end
        end
    endfunction

    function automatic void apply_reg(input logic [7:0] index, input logic [7:0] value);
        if (index == REG_RLE_MODE)
            rle_on = value[0];
        else if (index == REG_INIT_LEVEL)
        begin
            silence_level = value[0];
            if (recorded == 32'd0)
                cur_level = silence_level;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Send one input transaction, with an optional idle burst ahead of it
    task automatic send_item(input logic kind, input logic level);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, level};
        do @(posedge clk); while (!s_axis_tready);
        encode_item(kind, level);
    endtask

    // Hold the input until every predicted byte has come out, then let it settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the bits above bit 0 carry random filler
    task automatic write_reg(input logic [7:0] index, input logic value);
        logic [7:0] data;
        data = {7'($urandom_range(0, 127)), value};
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Output side: stall in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        enc_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output transaction: out_byte %0h sample_count %0d",
                       m_axis_tdata[7:0], m_axis_tdata[39:8]);
                mismatch_cnt++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata[7:0] !== want.code)
                begin
                    $error("out_byte: expected %0h, got %0h", want.code, m_axis_tdata[7:0]);
                    mismatch_cnt++;
                end
                if (m_axis_tuser !== want.has_data)
                begin
                    $error("has_data: expected %0b, got %0b", want.has_data, m_axis_tuser);
                    mismatch_cnt++;
                end
                if (m_axis_tdata[39:8] !== want.count)
                begin
                    $error("sample_count: expected %0d, got %0d", want.count,
                           m_axis_tdata[39:8]);
                    mismatch_cnt++;
                end
                if (m_axis_tlast !== want.tail)
                begin
                    $error("last: expected %0b, got %0b", want.tail, m_axis_tlast);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tape_level_rle_byte_encoder_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset settings: empty flush, leading silence, first run with its extra count
    task automatic test_leading_silence();
        send_item(KIND_FINISH, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_FINISH, 1'b1);
        wait_idle();
    endtask

    // Raw bytes with high silence, count-only report, unknown register index
    task automatic test_raw_mode();
        write_reg(REG_RLE_MODE, 1'b0);
        write_reg(REG_INIT_LEVEL, 1'b1);
        write_reg(8'($urandom_range(2, 255)), 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_FINISH, 1'b0);
        wait_idle();
    endtask

    // Change the silence level and the mode in the middle of a recording
    task automatic test_mid_recording_changes();
        write_reg(REG_RLE_MODE, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b0);
        wait_idle();
        write_reg(REG_INIT_LEVEL, 1'b0);
        send_item(KIND_TICK, 1'b1);
        wait_idle();
        write_reg(REG_RLE_MODE, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        wait_idle();
        write_reg(REG_RLE_MODE, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_FINISH, 1'b0);
        wait_idle();
    endtask

    // A run above 255 closed by a level change, then a short flush
    task automatic test_long_runs();
        write_reg(REG_RLE_MODE, 1'b1);
        write_reg(REG_INIT_LEVEL, 1'b0);
        repeat (258) send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_FINISH, 1'b0);
        wait_idle();
    endtask

    // Random recordings: mostly level runs, some noise ticks and flushes
    task automatic test_random_recordings(input int n_items, input logic mode,
                                          input logic init);
        int sent;
        int run;
        int pick;
        logic lvl;
        write_reg(REG_RLE_MODE, mode);
        write_reg(REG_INIT_LEVEL, init);
        lvl  = 1'($urandom);
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                send_item(KIND_FINISH, 1'($urandom));
                sent++;
            end
            else if (pick < 20)
            begin
                send_item(KIND_TICK, 1'($urandom));
                sent++;
            end
            else
            begin
                run = $urandom_range(1, 12);
                lvl = ~lvl;
                repeat (run) send_item(KIND_TICK, lvl);
                sent += run;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rle_on        = 1'b1;
        silence_level = 1'b0;
        restart_recording();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_leading_silence();
        test_raw_mode();
        test_mid_recording_changes();
        test_long_runs();
        test_random_recordings(12, 1'b1, 1'b0);
        test_random_recordings(8, 1'b0, 1'b1);
        test_random_recordings(12, 1'b1, 1'b1);
        test_random_recordings(8, 1'b0, 1'b0);
        // Last part runs at full rate on both sides
        idle_on = 1'b0;
        test_random_recordings(12, 1'($urandom), 1'($urandom));

        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tape_level_rle_byte_encoder_unit: match");
        else
            $display("tape_level_rle_byte_encoder_unit: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/tlre_pkg.sv
hdl/tlre_front.sv
hdl/tlre_fifo.sv
hdl/tlre_back.sv
hdl/tape_level_rle_byte_encoder_unit.sv
sim/tape_level_rle_byte_encoder_unit_test.sv
